FILE: rtl/sha256_pkg.sv
// Shared types, constants and round functions of the SHA-256 message hasher.
package sha256_pkg;

    localparam int unsigned WordW     = 32;
    localparam int unsigned BlockWords = 16;
    localparam int unsigned Rounds    = 64;
    localparam int unsigned DigestWords = 8;

    localparam logic [7:0] PadByte = 8'h80;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       no_byte;
        logic       end_of_message;
    } sha_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } sha_out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROUND,
        S_FINISH,
        S_PAD1,
        S_PAD2,
        S_OUT
    } sha_state_t;

    localparam logic [31:0] InitHash [DigestWords] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] RoundK [Rounds] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] sig0(input logic [31:0] x);
        sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sig1(input logic [31:0] x);
        sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

FILE: rtl/sha256_message_hasher_core.sv
// SHA-256 message hasher: byte gathering, padding, iterative compression, digest output.
// Each byte item is taken while idle; a full 64-byte block then holds off the input for
// 64 rounds through the one round unit and a chaining add. A closing item adds, per final
// block (one or two), a pad step, 64 rounds and a chaining add, then eight digest items,
// one per cycle while taken. Reset (rst_n low, asynchronous) loads the initial hash values
// and clears the byte and bit counts.
module sha256_message_hasher_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  sha256_pkg::sha_in_t  item,
    output logic                 digest_valid,
    input  logic                 digest_ready,
    output sha256_pkg::sha_out_t digest
);
    import sha256_pkg::*;

    sha_state_t  state_reg, state_next;

    logic [31:0] hash_reg [DigestWords];
    logic [31:0] w_reg [BlockWords];
    logic [31:0] v_reg [DigestWords];
    logic [5:0]  fill_reg;
    logic [31:0] total_reg;
    logic [5:0]  round_reg;
    logic [2:0]  out_idx_reg;
    logic        end_reg;
    logic        padded_reg;
    logic        second_reg;

    logic        accept_in;
    logic        accept_out;
    logic        byte_in;
    logic        block_full;
    logic [5:0]  fill_inc;
    logic [31:0] w_new;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] pad_word [BlockWords];

    assign accept_in  = item_valid && item_ready;
    assign accept_out = digest_valid && digest_ready;
    assign byte_in    = !item.no_byte;
    assign fill_inc   = fill_reg + 6'd1;
    assign block_full = byte_in && (fill_inc == 6'd0);

    always_comb
    begin
        if (round_reg[5:4] == 2'b00)
        begin
            w_new = w_reg[0];
        end
        else
        begin
            w_new = w_reg[0] + sig0(w_reg[1]) + w_reg[9] + sig1(w_reg[14]);
        end
        t1 = v_reg[7] + bsig1(v_reg[4]) + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
           + RoundK[round_reg] + w_new;
        t2 = bsig0(v_reg[0])
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    // mark end of data, clear the tail, place the length when it fits
    always_comb
    begin
        for (int i = 0; i < BlockWords; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                if (6'(4 * i + j) == fill_reg)
                begin
                    pad_word[i][8 * (3 - j) +: 8] = PadByte;
                end
                else if (6'(4 * i + j) > fill_reg)
                begin
                    pad_word[i][8 * (3 - j) +: 8] = 8'h00;
                end
                else
                begin
                    pad_word[i][8 * (3 - j) +: 8] = w_reg[i][8 * (3 - j) +: 8];
                end
            end
        end
        if (fill_reg <= 6'd55)
        begin
            pad_word[BlockWords - 2] = 32'h0;
            pad_word[BlockWords - 1] = total_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept_in)
                begin
                    if (block_full)
                    begin
                        state_next = S_ROUND;
                    end
                    else if (item.end_of_message)
                    begin
                        state_next = S_PAD1;
                    end
                end
            end
            S_ROUND:
            begin
                if (round_reg == 6'd63)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!end_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (!padded_reg)
                begin
                    state_next = S_PAD1;
                end
                else if (second_reg)
                begin
                    state_next = S_PAD2;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_PAD1, S_PAD2:
            begin
                state_next = S_ROUND;
            end
            S_OUT:
            begin
                if (accept_out && (out_idx_reg == 3'd7))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_ready         = (state_reg == S_IDLE);
        digest_valid       = (state_reg == S_OUT);
        digest.digest_word = hash_reg[out_idx_reg];
        digest.word_index  = out_idx_reg;
        digest.last_word   = (out_idx_reg == 3'd7);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            total_reg   <= '0;
            round_reg   <= '0;
            out_idx_reg <= '0;
            end_reg     <= 1'b0;
            padded_reg  <= 1'b0;
            second_reg  <= 1'b0;
            for (int i = 0; i < DigestWords; i++)
            begin
                hash_reg[i] <= InitHash[i];
            end
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept_in)
                    begin
                        end_reg    <= item.end_of_message;
                        padded_reg <= 1'b0;
                        if (byte_in)
                        begin
                            fill_reg  <= fill_inc;
                            total_reg <= total_reg + 32'd8;
                        end
                    end
                end
                S_ROUND:
                begin
                    round_reg <= round_reg + 6'd1;
                end
                S_FINISH:
                begin
                    for (int i = 0; i < DigestWords; i++)
                    begin
                        hash_reg[i] <= hash_reg[i] + v_reg[i];
                    end
                end
                S_PAD1:
                begin
                    padded_reg <= 1'b1;
                    second_reg <= (fill_reg > 6'd55);
                end
                S_PAD2:
                begin
                    second_reg <= 1'b0;
                end
                S_OUT:
                begin
                    if (accept_out)
                    begin
                        out_idx_reg <= out_idx_reg + 3'd1;
                        if (out_idx_reg == 3'd7)
                        begin
                            fill_reg  <= '0;
                            total_reg <= '0;
                            for (int i = 0; i < DigestWords; i++)
                            begin
                                hash_reg[i] <= InitHash[i];
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // schedule window and working variables
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept_in && byte_in)
                begin
                    w_reg[fill_reg[5:2]][8 * (3 - int'(fill_reg[1:0])) +: 8] <= item.data_byte;
                end
                for (int i = 0; i < DigestWords; i++)
                begin
                    v_reg[i] <= hash_reg[i];
                end
            end
            S_ROUND:
            begin
                for (int i = 0; i < BlockWords - 1; i++)
                begin
                    w_reg[i] <= w_reg[i + 1];
                end
                w_reg[BlockWords - 1] <= w_new;
                v_reg[7] <= v_reg[6];
                v_reg[6] <= v_reg[5];
                v_reg[5] <= v_reg[4];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[3] <= v_reg[2];
                v_reg[2] <= v_reg[1];
                v_reg[1] <= v_reg[0];
                v_reg[0] <= t1 + t2;
            end
            S_FINISH:
            begin
                for (int i = 0; i < DigestWords; i++)
                begin
                    v_reg[i] <= hash_reg[i] + v_reg[i];
                end
            end
            S_PAD1:
            begin
                for (int i = 0; i < BlockWords; i++)
                begin
                    w_reg[i] <= pad_word[i];
                end
            end
            S_PAD2:
            begin
                for (int i = 0; i < BlockWords - 1; i++)
                begin
                    w_reg[i] <= 32'h0;
                end
                w_reg[BlockWords - 1] <= total_reg;
            end
            default:
            begin
            end
        endcase
    end

    a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid |-> !item_ready)
        else $error("input taken while digest pending");

    a_first_word: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(digest_valid) |-> (digest.word_index == 3'd0))
        else $error("digest does not start at word 0");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept_out && digest.last_word) |=>
            (fill_reg == 6'd0 && total_reg == 32'd0 && hash_reg[0] == InitHash[0]))
        else $error("state not returned to initial after digest");

    a_round_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_ROUND) |-> (round_reg == 6'd0))
        else $error("round counter not at zero outside rounds");

endmodule
